// ===== src/direct_circle_rasterizer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the circle rasterizer.
// ----------------------------------------------------------------------------
`ifndef DIRECT_CIRCLE_RASTERIZER_MACROS_SVH
`define DIRECT_CIRCLE_RASTERIZER_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define DCR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define DCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/dcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Circle rasterizer package
// Widths, register indexes and the request/response types of the root unit.
// ----------------------------------------------------------------------------
package dcr_pkg;

	localparam int COORD_BITS    = 12;
	localparam int OUT_BITS      = COORD_BITS + 2;
	localparam int COLOR_BITS    = 24;
	localparam int ARG_BITS      = 2 * COORD_BITS;
	localparam int CNT_BITS      = $clog2(COORD_BITS);
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = COLOR_BITS;
	localparam int PIX_CNT_BITS  = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X   = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y   = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS     = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] REG_DRAW_COLOR = CFG_IDX_BITS'(3);

	localparam logic [PIX_CNT_BITS-1:0] LAST_PIX = '1;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic   start;
		coord_t radius;
		coord_t column;
	} root_req_t;

	typedef struct packed {
		logic   valid;
		coord_t row;
	} root_rsp_t;

endpackage

// ===== src/dcr_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying the restart/advance request.
// ----------------------------------------------------------------------------
interface dcr_cmd_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

// ===== src/dcr_pixel_if.sv =====
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one rasterized pixel.
// ----------------------------------------------------------------------------
interface dcr_pixel_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [dcr_pkg::OUT_BITS-1:0]  pixel_x;
	logic signed [dcr_pkg::OUT_BITS-1:0]  pixel_y;
	logic [dcr_pkg::COLOR_BITS-1:0]       pixel_color;
	logic                                 last_of_step;
	logic                                 circle_done;

	modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
		output last_of_step, output circle_done, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input pixel_color,
		input last_of_step, input circle_done, output ready);
endinterface

// ===== src/dcr_root.sv =====
// ----------------------------------------------------------------------------
// Row root unit
// Bit-serial (r-c)*(r+c) followed by a two-bits-per-cycle restoring square
// root, rounded to the nearest integer.
// ----------------------------------------------------------------------------
`include "direct_circle_rasterizer_macros.svh"

module dcr_root (
	input  logic               clk,
	input  logic               arst_n,
	input  dcr_pkg::root_req_t req,
	output dcr_pkg::root_rsp_t rsp
);

	typedef enum logic [3:0] {
		RU_IDLE = 4'b0001,
		RU_MUL  = 4'b0010,
		RU_ROOT = 4'b0100,
		RU_RND  = 4'b1000
	} ru_state_t;

	localparam int REM_BITS = dcr_pkg::COORD_BITS + 2;
	localparam int TMP_BITS = dcr_pkg::COORD_BITS + 4;

	ru_state_t                         state_q;
	logic [dcr_pkg::CNT_BITS-1:0]      cnt_q;
	logic [dcr_pkg::COORD_BITS:0]      mcand_q;
	logic [dcr_pkg::COORD_BITS-1:0]    mplier_q;
	logic [dcr_pkg::ARG_BITS-1:0]      acc_q;
	logic [REM_BITS-1:0]               rem_q;
	dcr_pkg::coord_t                   root_q;

	logic [dcr_pkg::ARG_BITS-1:0]      acc_sum;
	logic [TMP_BITS-1:0]               rem_t;
	logic [TMP_BITS-1:0]               trial;
	logic                              fits;
	logic [REM_BITS-1:0]               root_dbl;

	// multiplier runs MSB first: acc = 2*acc + bit*mcand
	assign acc_sum = {acc_q[dcr_pkg::ARG_BITS-2:0], 1'b0}
		+ (mplier_q[dcr_pkg::COORD_BITS-1] ? dcr_pkg::ARG_BITS'(mcand_q) : '0);

	assign rem_t = {rem_q, acc_q[dcr_pkg::ARG_BITS-1 -: 2]};
	assign trial = TMP_BITS'({root_q, 2'b01});
	assign fits  = rem_t >= trial;
	assign root_dbl = REM_BITS'({root_q, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RU_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				RU_IDLE: begin
					if (req.start) begin
						state_q <= RU_MUL;
						cnt_q   <= dcr_pkg::CNT_BITS'(dcr_pkg::COORD_BITS - 1);
					end
				end
				RU_MUL: begin
					if (cnt_q == '0) begin
						state_q <= RU_ROOT;
						cnt_q   <= dcr_pkg::CNT_BITS'(dcr_pkg::COORD_BITS - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				RU_ROOT: begin
					if (cnt_q == '0) begin
						state_q <= RU_RND;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				RU_RND: begin
					state_q <= RU_IDLE;
				end
				default: begin
					state_q <= RU_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			RU_IDLE: begin
				if (req.start) begin
					acc_q <= '0;
					// argument saturates at zero once the column passes the radius
					if (req.radius > req.column) begin
						mcand_q  <= {1'b0, req.radius} + {1'b0, req.column};
						mplier_q <= req.radius - req.column;
					end else begin
						mcand_q  <= '0;
						mplier_q <= '0;
					end
				end
			end
			RU_MUL: begin
				acc_q    <= acc_sum;
				mplier_q <= {mplier_q[dcr_pkg::COORD_BITS-2:0], 1'b0};
				if (cnt_q == '0) begin
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			RU_ROOT: begin
				acc_q  <= {acc_q[dcr_pkg::ARG_BITS-3:0], 2'b00};
				root_q <= {root_q[dcr_pkg::COORD_BITS-2:0], fits};
				rem_q  <= fits ? REM_BITS'(rem_t - trial) : REM_BITS'(rem_t);
			end
			RU_RND: begin
			end
			default: begin
			end
		endcase
	end

	// v - n*n > n  means the true root lies above n + 1/2
	always_comb begin
		rsp.valid = (state_q == RU_RND);
		rsp.row   = (rem_q > REM_BITS'(root_q)) ? root_q + 1'b1 : root_q;
	end

	`DCR_ASSERT_SAME(a_start_idle, clk, arst_n, req.start, state_q == RU_IDLE, "root request while busy")
	`DCR_ASSERT_NEXT(a_mul_to_root, clk, arst_n, state_q == RU_MUL && cnt_q == '0, state_q == RU_ROOT && root_q == '0, "root phase not entered cleanly")
	`DCR_ASSERT_SAME(a_rem_bound, clk, arst_n, state_q == RU_RND, rem_q <= root_dbl, "root remainder out of range")
	`DCR_ASSERT_NEXT(a_rsp_pulse, clk, arst_n, rsp.valid, state_q == RU_IDLE, "root response longer than one cycle")

endmodule

// ===== src/direct_circle_rasterizer.sv =====
// Restart request: state moves to S_EMIT and the first pixel is registered out,
// then one pixel per cycle while the sink is ready. Advance request: the root unit
// runs its multiply, root and round phases before the first pixel is registered.
// Advance while idle: accepted and dropped. Next request taken once pixel 8 is loaded.
// Reset (arst_n low, async): control, offsets and registers clear; no clearing pass.
// ----------------------------------------------------------------------------
// Direct circle rasterizer
// Octant walk with square-root rows, eight-way mirrored pixel output.
// ----------------------------------------------------------------------------
`include "direct_circle_rasterizer_macros.svh"

module direct_circle_rasterizer (
	input  logic                               clk,
	input  logic                               arst_n,
	dcr_cmd_if.sink                            cmd,
	dcr_pixel_if.source                        pixel,
	input  logic                               cfg_wen,
	input  logic [dcr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [dcr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_ROOT = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t                               state_q;
	dcr_pkg::coord_t                      center_x_q;
	dcr_pkg::coord_t                      center_y_q;
	dcr_pkg::coord_t                      radius_q;
	logic [dcr_pkg::COLOR_BITS-1:0]       color_q;
	dcr_pkg::coord_t                      col_q;
	dcr_pkg::coord_t                      row_q;
	logic                                 active_q;
	logic                                 done_q;
	logic [dcr_pkg::PIX_CNT_BITS-1:0]     pix_q;
	logic                                 out_vld_q;
	logic signed [dcr_pkg::OUT_BITS-1:0]  px_q;
	logic signed [dcr_pkg::OUT_BITS-1:0]  py_q;
	logic [dcr_pkg::COLOR_BITS-1:0]       pcolor_q;
	logic                                 plast_q;
	logic                                 pdone_q;

	logic                                 accept;
	logic                                 load;
	dcr_pkg::coord_t                      col_inc;
	dcr_pkg::root_req_t                   root_req;
	dcr_pkg::root_rsp_t                   root_rsp;
	logic                                 swap;
	logic                                 neg_x;
	logic                                 neg_y;
	dcr_pkg::coord_t                      off_x;
	dcr_pkg::coord_t                      off_y;
	logic [dcr_pkg::OUT_BITS-1:0]         cx_ext;
	logic [dcr_pkg::OUT_BITS-1:0]         cy_ext;
	logic [dcr_pkg::OUT_BITS-1:0]         ox_ext;
	logic [dcr_pkg::OUT_BITS-1:0]         oy_ext;
	logic [dcr_pkg::OUT_BITS-1:0]         px_next;
	logic [dcr_pkg::OUT_BITS-1:0]         py_next;

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign load      = (state_q == S_EMIT) && (!out_vld_q || pixel.ready);
	assign col_inc   = col_q + 1'b1;

	always_comb begin
		root_req.start  = accept && !cmd.restart && active_q;
		root_req.radius = radius_q;
		root_req.column = col_inc;
	end

	dcr_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (root_req),
		.rsp    (root_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= '0;
			color_q    <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				dcr_pkg::REG_CENTER_X:   center_x_q <= cfg_data[dcr_pkg::COORD_BITS-1:0];
				dcr_pkg::REG_CENTER_Y:   center_y_q <= cfg_data[dcr_pkg::COORD_BITS-1:0];
				dcr_pkg::REG_RADIUS:     radius_q   <= cfg_data[dcr_pkg::COORD_BITS-1:0];
				dcr_pkg::REG_DRAW_COLOR: color_q    <= cfg_data[dcr_pkg::COLOR_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			col_q     <= '0;
			row_q     <= '0;
			active_q  <= 1'b0;
			done_q    <= 1'b0;
			pix_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (pixel.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd.restart) begin
							col_q    <= '0;
							row_q    <= radius_q;
							active_q <= (radius_q != '0);
							done_q   <= (radius_q == '0);
							pix_q    <= '0;
							state_q  <= S_EMIT;
						end else if (active_q) begin
							col_q   <= col_inc;
							state_q <= S_ROOT;
						end
					end
				end
				S_ROOT: begin
					if (root_rsp.valid) begin
						row_q    <= root_rsp.row;
						active_q <= (col_q < root_rsp.row);
						done_q   <= !(col_q < root_rsp.row);
						pix_q    <= '0;
						state_q  <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (load) begin
						pix_q <= pix_q + 1'b1;
						if (pix_q == dcr_pkg::LAST_PIX) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// mirror order: (+x,+y) (-x,+y) (-x,-y) (+x,-y) (+y,+x) (-y,+x) (+y,-x) (-y,-x)
	always_comb begin
		unique case (pix_q)
			3'd0: {swap, neg_x, neg_y} = 3'b000;
			3'd1: {swap, neg_x, neg_y} = 3'b010;
			3'd2: {swap, neg_x, neg_y} = 3'b011;
			3'd3: {swap, neg_x, neg_y} = 3'b001;
			3'd4: {swap, neg_x, neg_y} = 3'b100;
			3'd5: {swap, neg_x, neg_y} = 3'b110;
			3'd6: {swap, neg_x, neg_y} = 3'b101;
			3'd7: {swap, neg_x, neg_y} = 3'b111;
			default: {swap, neg_x, neg_y} = 3'b000;
		endcase
	end

	assign off_x   = swap ? row_q : col_q;
	assign off_y   = swap ? col_q : row_q;
	assign cx_ext  = dcr_pkg::OUT_BITS'(center_x_q);
	assign cy_ext  = dcr_pkg::OUT_BITS'(center_y_q);
	assign ox_ext  = dcr_pkg::OUT_BITS'(off_x);
	assign oy_ext  = dcr_pkg::OUT_BITS'(off_y);
	assign px_next = neg_x ? cx_ext - ox_ext : cx_ext + ox_ext;
	assign py_next = neg_y ? cy_ext - oy_ext : cy_ext + oy_ext;

	always_ff @(posedge clk) begin
		if (load) begin
			px_q     <= $signed(px_next);
			py_q     <= $signed(py_next);
			pcolor_q <= color_q;
			plast_q  <= (pix_q == dcr_pkg::LAST_PIX);
			pdone_q  <= done_q;
		end
	end

	assign pixel.valid        = out_vld_q;
	assign pixel.pixel_x      = px_q;
	assign pixel.pixel_y      = py_q;
	assign pixel.pixel_color  = pcolor_q;
	assign pixel.last_of_step = plast_q;
	assign pixel.circle_done  = pdone_q;

	`DCR_ASSERT_NEXT(a_restart_emits, clk, arst_n, accept && cmd.restart, state_q == S_EMIT && pix_q == '0, "restart did not start pixel output")
	`DCR_ASSERT_SAME(a_active_order, clk, arst_n, active_q && state_q == S_IDLE, col_q < row_q, "active circle with column past row")
	`DCR_ASSERT_NEXT(a_last_pix_idle, clk, arst_n, load && pix_q == dcr_pkg::LAST_PIX, state_q == S_IDLE && pixel.valid && pixel.last_of_step, "eighth pixel not closing the step")
	`DCR_ASSERT_SAME(a_rsp_in_wait, clk, arst_n, root_rsp.valid, state_q == S_ROOT, "root response outside wait state")

endmodule
